// ===== rtl/s7ch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S7comm+ header detector package
// Shared types, header constants and the function code lookup.
// ----------------------------------------------------------------------------
package s7ch_pkg;

  // Header byte positions, followed by the two decided positions.
  typedef enum logic [4:0] {
    POS_TPKT_VER    = 5'd0,
    POS_TPKT_RSV    = 5'd1,
    POS_TPKT_LEN_HI = 5'd2,
    POS_TPKT_LEN_LO = 5'd3,
    POS_COTP_LEN    = 5'd4,
    POS_COTP_PDU    = 5'd5,
    POS_COTP_TPDU   = 5'd6,
    POS_PROTO_ID    = 5'd7,
    POS_PDU_TYPE    = 5'd8,
    POS_DLEN_HI     = 5'd9,
    POS_DLEN_LO     = 5'd10,
    POS_OPCODE      = 5'd11,
    POS_RSV_HI      = 5'd12,
    POS_RSV_LO      = 5'd13,
    POS_FUNC_HI     = 5'd14,
    POS_FUNC_LO     = 5'd15,
    POS_MATCH       = 5'd16,
    POS_NOMATCH     = 5'd17
  } pos_e;

  // Verdict codes reported for every byte.
  typedef enum logic [1:0] {
    V_PENDING = 2'd0,
    V_MATCH   = 2'd1,
    V_NOMATCH = 2'd2,
    V_SKIP    = 2'd3
  } verdict_e;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] payload;
    logic       last;
  } beat_t;

  // Fixed header field values.
  localparam logic [3:0] CotpPduNibble = 4'hF;
  localparam logic [7:0] ProtoId       = 8'h72;
  localparam logic [7:0] PduTypeA      = 8'h01;
  localparam logic [7:0] PduTypeB      = 8'h02;
  localparam logic [7:0] PduTypeC      = 8'h03;
  localparam logic [7:0] PduTypeD      = 8'hFF;
  localparam logic [7:0] OpcodeA       = 8'h31;
  localparam logic [7:0] OpcodeB       = 8'h32;
  localparam logic [7:0] OpcodeC       = 8'h33;
  localparam logic [7:0] OpcodeD       = 8'h02;

  // Known function codes.
  localparam int NumKnown = 11;
  localparam logic [15:0] KnownFunctions [NumKnown] = '{
    16'h04BB, 16'h04CA, 16'h04D4, 16'h04F2, 16'h0524, 16'h0542,
    16'h054C, 16'h0556, 16'h0560, 16'h056B, 16'h0586
  };

  // True when the code is one of the known function codes.
  function automatic logic function_known(input logic [15:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumKnown; i++) begin
      hit = hit | (code == KnownFunctions[i]);
    end
    return hit;
  endfunction

endpackage

// ===== rtl/s7ch_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S7comm+ header walker
// Holds the parse position, the function code high byte and the skip flag,
// and produces the verdict for the beat that steps it.
// ----------------------------------------------------------------------------
module s7ch_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  s7ch_pkg::beat_t    beat_i,
  output s7ch_pkg::verdict_e verdict_o
);

  s7ch_pkg::pos_e pos_q, pos_d;
  logic [7:0]     func_high_q, func_high_d;
  logic           skip_q, skip_d;
  logic [7:0]     b;

  assign b = beat_i.payload;

  // Next state and verdict for the current beat.
  always_comb begin
    pos_d       = pos_q;
    func_high_d = func_high_q;
    skip_d      = skip_q;
    verdict_o   = s7ch_pkg::V_PENDING;
    if (skip_q) begin
      verdict_o = s7ch_pkg::V_SKIP;
      if (beat_i.last) begin
        skip_d = 1'b0;
      end
    end else begin
      unique case (pos_q)
        s7ch_pkg::POS_MATCH: begin
          verdict_o = s7ch_pkg::V_MATCH;
          pos_d     = s7ch_pkg::POS_TPKT_VER;
          skip_d    = !beat_i.last;
        end
        s7ch_pkg::POS_NOMATCH: begin
          verdict_o = s7ch_pkg::V_NOMATCH;
          pos_d     = s7ch_pkg::POS_TPKT_VER;
          skip_d    = !beat_i.last;
        end
        s7ch_pkg::POS_COTP_PDU: begin
          pos_d = (b[7:4] == s7ch_pkg::CotpPduNibble) ? s7ch_pkg::POS_COTP_TPDU
                                                      : s7ch_pkg::POS_NOMATCH;
        end
        s7ch_pkg::POS_PROTO_ID: begin
          pos_d = (b == s7ch_pkg::ProtoId) ? s7ch_pkg::POS_PDU_TYPE
                                           : s7ch_pkg::POS_NOMATCH;
        end
        s7ch_pkg::POS_PDU_TYPE: begin
          pos_d = (b == s7ch_pkg::PduTypeA || b == s7ch_pkg::PduTypeB ||
                   b == s7ch_pkg::PduTypeC || b == s7ch_pkg::PduTypeD)
                  ? s7ch_pkg::POS_DLEN_HI : s7ch_pkg::POS_NOMATCH;
        end
        s7ch_pkg::POS_OPCODE: begin
          pos_d = (b == s7ch_pkg::OpcodeA || b == s7ch_pkg::OpcodeB ||
                   b == s7ch_pkg::OpcodeC || b == s7ch_pkg::OpcodeD)
                  ? s7ch_pkg::POS_RSV_HI : s7ch_pkg::POS_NOMATCH;
        end
        s7ch_pkg::POS_FUNC_HI: begin
          func_high_d = b;
          pos_d       = s7ch_pkg::POS_FUNC_LO;
        end
        s7ch_pkg::POS_FUNC_LO: begin
          pos_d = s7ch_pkg::function_known({func_high_q, b}) ? s7ch_pkg::POS_MATCH
                                                             : s7ch_pkg::POS_NOMATCH;
        end
        default: begin
          // Codes past the decided positions fall back to no match.
          if (pos_q > s7ch_pkg::POS_NOMATCH) begin
            pos_d = s7ch_pkg::POS_NOMATCH;
          end else begin
            pos_d = s7ch_pkg::pos_e'(5'(pos_q + 5'd1));
          end
        end
      endcase
    end
  end

  // Walker state advances only on a stepping beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= s7ch_pkg::POS_TPKT_VER;
      func_high_q <= 8'h00;
      skip_q      <= 1'b0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      func_high_q <= func_high_d;
      skip_q      <= skip_d;
    end
  end

`ifndef ASSERT_OFF
  // While skipping, the parser always waits at the start of a header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> pos_q == s7ch_pkg::POS_TPKT_VER)
    else $error("skip flag set away from header start");

  // A reported verdict returns the parser to the start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !skip_q && (pos_q == s7ch_pkg::POS_MATCH || pos_q == s7ch_pkg::POS_NOMATCH)
    |=> pos_q == s7ch_pkg::POS_TPKT_VER)
    else $error("parser did not restart after verdict");

  // The function code high byte is captured from its beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !skip_q && pos_q == s7ch_pkg::POS_FUNC_HI
    |=> func_high_q == $past(beat_i.payload) && pos_q == s7ch_pkg::POS_FUNC_LO)
    else $error("function code high byte not captured");

  // A skipped beat that ends its buffer clears the skip flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && skip_q && beat_i.last |=> !skip_q)
    else $error("skip flag survived buffer end");
`endif

endmodule

// ===== rtl/s7commplus_header_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S7comm+ header detector
// Walks TPKT/COTP/S7comm+ headers in a byte stream and reports one verdict
// per byte: pending, match, no match or skipped.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i / in_stall_o payload_byte_i, buffer_end_i
//  out      output     out_valid_o/out_stall_i verdict_o
//
//  One byte is accepted per cycle while in_stall_o is low; its verdict is
//  written to the verdict register when the byte leaves the input register.
//  The combinational header walker lies between the input register and the
//  verdict register.
//  Reset returns the parser to the TPKT version byte and empties both stages.
//  A stalled output holds its verdict; input stalls only when both stages
//  are full and the output is stalled.
// ----------------------------------------------------------------------------
module s7commplus_header_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] payload_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);

  logic               in_valid_q;
  s7ch_pkg::beat_t    beat_q;
  logic               out_valid_q;
  s7ch_pkg::verdict_e verdict_q;
  s7ch_pkg::verdict_e verdict_d;
  logic               advance;
  logic               in_accept;

  // A held beat moves on when the verdict register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || (in_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      beat_q.payload <= payload_byte_i;
      beat_q.last    <= buffer_end_i;
    end
  end

  s7ch_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .beat_i    (beat_q),
    .verdict_o (verdict_d)
  );

  // Verdict register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = 2'(verdict_q);

`ifndef ASSERT_OFF
  // A held beat that cannot move stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input beat lost while blocked");

  // A beat moving on always fills the verdict register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("verdict register not filled");

  // A stalled verdict holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(verdict_q))
    else $error("stalled verdict changed");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S7comm+ header detector testbench
// Streams directed and random TPKT/COTP/S7comm+ header bytes into the
// detector with random gaps and output stalls. A scoreboard walks the same
// header layout per accepted input beat and checks every verdict in order.
// ----------------------------------------------------------------------------
module tb_top;

  // Header field values and the known function codes.
  localparam logic [3:0]  CotpNibble = 4'hF;
  localparam logic [7:0]  S7ProtoId  = 8'h72;
  localparam logic [7:0]  PduTypes [4] = '{8'h01, 8'h02, 8'h03, 8'hFF};
  localparam logic [7:0]  Opcodes  [4] = '{8'h31, 8'h32, 8'h33, 8'h02};
  localparam logic [15:0] FuncCodes [11] = '{
    16'h04BB, 16'h04CA, 16'h04D4, 16'h04F2, 16'h0524, 16'h0542,
    16'h054C, 16'h0556, 16'h0560, 16'h056B, 16'h0586
  };
  localparam int NumRandomBytes = 2000;
  localparam int MaxGap         = 17;
  localparam int WatchdogLimit  = 1000;
  localparam int DrainCycles    = 8;

  typedef struct {
    logic [7:0] payload;
    logic       last;
  } frame_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] payload_byte_i;
  logic       buffer_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] verdict_o;

  s7commplus_header_detector u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .payload_byte_i (payload_byte_i),
    .buffer_end_i   (buffer_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o)
  );

  // Field value checks for the scoreboard; the PDU type and opcode checks also serve the frame builder.
  function automatic bit is_pdu_type(input logic [7:0] b);
    return (b == PduTypes[0]) || (b == PduTypes[1]) ||
           (b == PduTypes[2]) || (b == PduTypes[3]);
  endfunction

  function automatic bit is_opcode(input logic [7:0] b);
    return (b == Opcodes[0]) || (b == Opcodes[1]) ||
           (b == Opcodes[2]) || (b == Opcodes[3]);
  endfunction

  function automatic bit is_known_code(input logic [15:0] code);
    bit hit;
    hit = 1'b0;
    foreach (FuncCodes[i]) begin
      if (FuncCodes[i] == code) hit = 1'b1;
    end
    return hit;
  endfunction

  // Header walker and the queue of verdicts still to come out.
  class verdict_scoreboard;
    s7ch_pkg::pos_e     hdr_pos;
    logic [7:0]         func_hi;
    bit                 skip_rest;
    s7ch_pkg::verdict_e verdict_q[$];
    int                 errors;

    function new();
      hdr_pos   = s7ch_pkg::POS_TPKT_VER;
      func_hi   = 8'h00;
      skip_rest = 1'b0;
      errors    = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Advances the header walk by one byte and returns its verdict.
    function s7ch_pkg::verdict_e walk_byte(input logic [7:0] b, input logic last);
      s7ch_pkg::verdict_e v;
      if (skip_rest) begin
        if (last) skip_rest = 1'b0;
        return s7ch_pkg::V_SKIP;
      end
      if (hdr_pos == s7ch_pkg::POS_MATCH || hdr_pos == s7ch_pkg::POS_NOMATCH) begin
        v = (hdr_pos == s7ch_pkg::POS_MATCH) ? s7ch_pkg::V_MATCH : s7ch_pkg::V_NOMATCH;
        hdr_pos   = s7ch_pkg::POS_TPKT_VER;
        skip_rest = !last;
        return v;
      end
      case (hdr_pos)
        s7ch_pkg::POS_COTP_PDU: begin
          hdr_pos = (b[7:4] == CotpNibble) ? s7ch_pkg::POS_COTP_TPDU
                                           : s7ch_pkg::POS_NOMATCH;
        end
        s7ch_pkg::POS_PROTO_ID: begin
          hdr_pos = (b == S7ProtoId) ? s7ch_pkg::POS_PDU_TYPE : s7ch_pkg::POS_NOMATCH;
        end
        s7ch_pkg::POS_PDU_TYPE: begin
          hdr_pos = is_pdu_type(b) ? s7ch_pkg::POS_DLEN_HI : s7ch_pkg::POS_NOMATCH;
        end
        s7ch_pkg::POS_OPCODE: begin
          hdr_pos = is_opcode(b) ? s7ch_pkg::POS_RSV_HI : s7ch_pkg::POS_NOMATCH;
        end
        s7ch_pkg::POS_FUNC_HI: begin
          func_hi = b;
          hdr_pos = s7ch_pkg::POS_FUNC_LO;
        end
        s7ch_pkg::POS_FUNC_LO: begin
          hdr_pos = is_known_code({func_hi, b}) ? s7ch_pkg::POS_MATCH
                                                : s7ch_pkg::POS_NOMATCH;
        end
        default: hdr_pos = s7ch_pkg::pos_e'(hdr_pos + 5'd1);
      endcase
      return s7ch_pkg::V_PENDING;
    endfunction

    // Called for every accepted input beat.
    function void note_byte(input logic [7:0] b, input logic last);
      verdict_q.push_back(walk_byte(b, last));
    endfunction

    // Called for every accepted output beat.
    task check_verdict(input logic [1:0] got);
      s7ch_pkg::verdict_e exp_v;
      if (verdict_q.size() == 0) begin
        report($sformatf("verdict %0d with no byte outstanding", got));
      end else begin
        exp_v = verdict_q.pop_front();
        if (got !== exp_v) begin
          report($sformatf("verdict got %0d expected %0d (%s)", got, exp_v, exp_v.name()));
        end
      end
    endtask

    function int outstanding();
      return verdict_q.size();
    endfunction

    task check_drained();
      if (verdict_q.size() != 0) begin
        report($sformatf("%0d verdicts never arrived", verdict_q.size()));
      end
    endtask
  endclass

  verdict_scoreboard sb = new();

  bit tx_quiet   = 1'b0;
  bit rx_quiet   = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int sent_count = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sends one input beat after a random gap and waits for it to be taken.
  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    payload_byte_i <= b;
    buffer_end_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, last);
    sent_count++;
  endtask

  // Builds one frame: mostly well-formed headers that may break at one check,
  // followed by trailing bytes; the rest is plain noise.
  task automatic send_frame();
    frame_beat_t frame[$];
    frame_beat_t fb;
    int          fail_at;
    int          fail_pos;
    int          trail;
    logic [7:0]  b;
    logic [15:0] code;
    tx_quiet = ($urandom_range(0, 3) == 0);
    code     = 16'h0000;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 24)) begin
        fb.payload = 8'($urandom_range(0, 255));
        fb.last    = ($urandom_range(0, 7) == 0);
        frame.push_back(fb);
      end
    end else begin
      fail_at = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
      case (fail_at)
        1:       fail_pos = 5;
        2:       fail_pos = 7;
        3:       fail_pos = 8;
        4:       fail_pos = 11;
        5:       fail_pos = 15;
        default: fail_pos = 16;
      endcase
      for (int p = 0; p < 16; p++) begin
        b = 8'($urandom_range(0, 255));
        case (p)
          5: b[7:4] = (fail_at == 1) ? 4'($urandom_range(0, 14)) : CotpNibble;
          7: begin
            if (fail_at == 2) begin
              while (b == S7ProtoId) b = 8'($urandom_range(0, 255));
            end else begin
              b = S7ProtoId;
            end
          end
          8: begin
            if (fail_at == 3) begin
              while (is_pdu_type(b)) b = 8'($urandom_range(0, 255));
            end else begin
              b = PduTypes[$urandom_range(0, 3)];
            end
          end
          11: begin
            if (fail_at == 4) begin
              while (is_opcode(b)) b = 8'($urandom_range(0, 255));
            end else begin
              b = Opcodes[$urandom_range(0, 3)];
            end
          end
          14: begin
            code = (fail_at == 5) ? 16'($urandom_range(0, 65535))
                                  : FuncCodes[$urandom_range(0, 10)];
            b = code[15:8];
          end
          15: b = code[7:0];
          default: ;
        endcase
        fb.payload = b;
        fb.last    = ($urandom_range(0, 15) == 0);
        frame.push_back(fb);
        if (p == fail_pos) break;
      end
      trail = $urandom_range(1, 8);
      repeat (trail) begin
        fb.payload = 8'($urandom_range(0, 255));
        fb.last    = ($urandom_range(0, 15) == 0);
        frame.push_back(fb);
      end
      if ($urandom_range(0, 4) != 0) frame[$].last = 1'b1;
    end
    foreach (frame[i]) send_beat(frame[i].payload, frame[i].last);
  endtask

  // Output side: checks each accepted verdict and draws the next stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_verdict(verdict_o);
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        stall_left = rx_quiet ? 0 : $urandom_range(0, MaxGap);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("s7commplus_header_detector verification failed");
      $finish;
    end
  end

  // Reset, directed bytes, random frames and the final drain.
  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    payload_byte_i <= 8'h00;
    buffer_end_i   <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // COTP type nibble fails; the verdict byte is followed by skipped bytes,
    // the last of which ends the buffer.
    send_beat(8'h03, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'h0E, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h55, 1'b1);

    // Full match decided on the last byte of a buffer; the verdict byte
    // itself ends the next buffer, so nothing is skipped.
    send_beat(8'h03, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h1A, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'hF0, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(S7ProtoId, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h0A, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h05, 1'b0);
    send_beat(8'h86, 1'b1);
    send_beat(8'h00, 1'b1);

    // Random frames.
    sent_count = 0;
    while (sent_count < NumRandomBytes) send_frame();
    in_valid_i <= 1'b0;

    // Drain the pipeline, then wait for stray beats before the final check.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.check_drained();

    if (sb.errors == 0) begin
      $display("s7commplus_header_detector verification clean");
    end else begin
      $display("s7commplus_header_detector verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/s7ch_pkg.sv
rtl/s7ch_walker.sv
rtl/s7commplus_header_detector.sv
tb/sv/tb_top.sv
